/* rtl/afmu_pkg.sv */
`timescale 1ns / 1ps

package afmu_pkg;

  localparam int NUM_CHARS     = 256;
  localparam int COUNT_BITS    = 16;
  localparam int NSYM          = NUM_CHARS + 1;
  localparam int ADDR_W        = $clog2(NUM_CHARS + 2);
  localparam int SYM_W         = 9;
  localparam int CHAR_W        = 8;
  localparam int TOTAL_W       = 16;
  localparam int MAX_TOTAL_RST = 16383;
  localparam int TOTAL_RST     = NSYM;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [TOTAL_W-1:0]    total_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESC,
    ST_RESC_END,
    ST_RD_CNT,
    ST_RD_PREV,
    ST_SEARCH,
    ST_RD_CH,
    ST_RD_LOW,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RESC,
    OP_RESC_END,
    OP_RD_CNT,
    OP_RD_PREV,
    OP_SEARCH,
    OP_RD_CH,
    OP_RD_LOW,
    OP_SWAP_A,
    OP_SWAP_B,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sym_bad;
    logic need_resc;
    logic addr_last;
    logic search_go;
    logic swap;
    logic out_free;
  } sts_t;

endpackage

/* rtl/afmu_ctrl.sv */
`timescale 1ns / 1ps

module afmu_ctrl
  import afmu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.addr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.sym_bad)        state_nxt = ST_DONE;
          else if (sts.need_resc) state_nxt = ST_RESC;
          else                    state_nxt = ST_RD_CNT;
        end
      end
      ST_RESC: begin
        if (sts.addr_last) state_nxt = ST_RESC_END;
      end
      ST_RESC_END: state_nxt = ST_RD_CNT;
      ST_RD_CNT:   state_nxt = ST_RD_PREV;
      ST_RD_PREV:  state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (!sts.search_go) state_nxt = ST_RD_CH;
      end
      ST_RD_CH:  state_nxt = ST_RD_LOW;
      ST_RD_LOW: state_nxt = sts.swap ? ST_SWAP_A : ST_DONE;
      ST_SWAP_A: state_nxt = ST_SWAP_B;
      ST_SWAP_B: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR:    cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_RESC:     cmd.op = OP_RESC;
      ST_RESC_END: cmd.op = OP_RESC_END;
      ST_RD_CNT:   cmd.op = OP_RD_CNT;
      ST_RD_PREV:  cmd.op = OP_RD_PREV;
      ST_SEARCH:   cmd.op = OP_SEARCH;
      ST_RD_CH:    cmd.op = OP_RD_CH;
      ST_RD_LOW:   cmd.op = OP_RD_LOW;
      ST_SWAP_A:   cmd.op = OP_SWAP_A;
      ST_SWAP_B:   cmd.op = OP_SWAP_B;
      ST_DONE: begin
        if (sts.out_free) cmd.op = OP_EMIT;
      end
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/afmu_dp.sv */
`timescale 1ns / 1ps

module afmu_dp
  import afmu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [SYM_W-1:0]   in_symbol_index,
  input  logic               cfg_valid,
  input  logic [TOTAL_W-1:0] cfg_max_total,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SYM_W-1:0]   out_new_index,
  output logic [CHAR_W-1:0]  out_char_at_index,
  output logic [TOTAL_W-1:0] out_total_count,
  output logic               out_rescaled
);

  count_t cnt_mem [0:NSYM];
  char_t  ic_mem  [0:NUM_CHARS];

  addr_t  addr_r;
  addr_t  sym_r;
  addr_t  pos_r;
  count_t cnt_sym_r;
  char_t  ch_r;
  total_t acc_r;
  total_t total_r;
  total_t max_total_r;
  logic   resc_r;

  count_t cnt_rd_r;
  char_t  ic_rd_r;

  logic   out_valid_r;
  addr_t  out_pos_r;
  char_t  out_ch_r;
  total_t out_total_r;
  logic   out_resc_r;

  logic   cnt_we, cnt_re, ic_we, ic_re;
  addr_t  cnt_wa, cnt_ra, ic_wa, ic_ra;
  count_t cnt_wd;
  char_t  ic_wd;

  logic [COUNT_BITS:0] cnt_inc;
  count_t              halved;
  total_t              acc_sum;
  addr_t               in_addr;
  logic                sym_bad;
  logic                last;

  assign cnt_inc = {1'b0, cnt_rd_r} + (COUNT_BITS + 1)'(1);
  assign halved  = cnt_inc[COUNT_BITS:1];
  assign acc_sum = acc_r + TOTAL_W'(halved);
  assign in_addr = ADDR_W'(in_symbol_index);
  assign sym_bad = (in_symbol_index == '0) || (in_symbol_index > SYM_W'(NUM_CHARS));
  assign last    = (addr_r == ADDR_W'(NSYM));

  assign sts.sym_bad   = sym_bad;
  assign sts.need_resc = (total_r >= max_total_r);
  assign sts.addr_last = last;
  assign sts.search_go = (pos_r > ADDR_W'(1)) && (cnt_rd_r == cnt_sym_r);
  assign sts.swap      = (pos_r != sym_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = addr_r;
    cnt_wd = '0;
    cnt_re = 1'b0;
    cnt_ra = addr_r;
    ic_we  = 1'b0;
    ic_wa  = addr_r;
    ic_wd  = '0;
    ic_re  = 1'b0;
    ic_ra  = sym_r;
    case (cmd.op)
      OP_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wd = (addr_r == '0) ? count_t'(0) : count_t'(1);
        ic_we  = (addr_r <= ADDR_W'(NUM_CHARS));
        ic_wd  = (addr_r == '0) ? char_t'(0) : CHAR_W'(addr_r - ADDR_W'(1));
      end
      OP_RESC: begin
        cnt_re = 1'b1;
        cnt_we = (addr_r != ADDR_W'(1));
        cnt_wa = addr_r - ADDR_W'(1);
        cnt_wd = halved;
      end
      OP_RESC_END: begin
        cnt_we = 1'b1;
        cnt_wa = ADDR_W'(NSYM);
        cnt_wd = halved;
      end
      OP_RD_CNT: begin
        cnt_re = 1'b1;
        cnt_ra = sym_r;
      end
      OP_RD_PREV: begin
        cnt_re = 1'b1;
        cnt_ra = pos_r - ADDR_W'(1);
      end
      OP_SEARCH: begin
        cnt_re = 1'b1;
        cnt_ra = pos_r - ADDR_W'(2);
      end
      OP_RD_CH: begin
        ic_re = 1'b1;
        ic_ra = sym_r;
      end
      OP_RD_LOW: begin
        ic_re  = 1'b1;
        ic_ra  = pos_r;
        cnt_we = 1'b1;
        cnt_wa = pos_r;
        cnt_wd = cnt_sym_r + count_t'(1);
      end
      OP_SWAP_A: begin
        ic_we = 1'b1;
        ic_wa = sym_r;
        ic_wd = ic_rd_r;
      end
      OP_SWAP_B: begin
        ic_we = 1'b1;
        ic_wa = pos_r;
        ic_wd = ch_r;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd_r <= cnt_mem[cnt_ra];
    if (ic_we) ic_mem[ic_wa] <= ic_wd;
    if (ic_re) ic_rd_r <= ic_mem[ic_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      total_r     <= TOTAL_W'(TOTAL_RST);
      max_total_r <= TOTAL_W'(MAX_TOTAL_RST);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) max_total_r <= cfg_max_total;
      case (cmd.op)
        OP_CLEAR: begin
          if (!last) addr_r <= addr_r + ADDR_W'(1);
        end
        OP_LOAD: begin
          addr_r <= ADDR_W'(1);
        end
        OP_RESC: begin
          if (!last) addr_r <= addr_r + ADDR_W'(1);
        end
        OP_RESC_END: begin
          total_r <= acc_sum;
        end
        OP_RD_LOW: begin
          total_r <= total_r + TOTAL_W'(1);
        end
        default: begin
          addr_r <= addr_r;
        end
      endcase
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        sym_r  <= in_addr;
        pos_r  <= sym_bad ? addr_t'(0) : in_addr;
        ch_r   <= '0;
        resc_r <= !sym_bad && (total_r >= max_total_r);
        acc_r  <= '0;
      end
      OP_RESC: begin
        if (addr_r != ADDR_W'(1)) acc_r <= acc_sum;
      end
      OP_RD_PREV: begin
        cnt_sym_r <= cnt_rd_r;
      end
      OP_SEARCH: begin
        if (sts.search_go) pos_r <= pos_r - ADDR_W'(1);
      end
      OP_RD_LOW: begin
        ch_r <= ic_rd_r;
      end
      OP_EMIT: begin
        out_pos_r   <= pos_r;
        out_ch_r    <= ch_r;
        out_total_r <= total_r;
        out_resc_r  <= resc_r;
      end
      default: begin
        pos_r <= pos_r;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_new_index     = SYM_W'(out_pos_r);
  assign out_char_at_index = out_ch_r;
  assign out_total_count   = out_total_r;
  assign out_rescaled      = out_resc_r;

endmodule

/* rtl/adaptive_freq_model_update.sv */
`timescale 1ns / 1ps

// Adaptive frequency model update for an arithmetic coder.
// Input channel (in_valid / in_stall) carries one word: the model index of
// the character just coded. Output channel (out_valid / out_stall) returns
// one word per input: new index, its character, the total count and a
// flag set when the counts were halved on that step.
// Configuration channel (cfg_valid / cfg_ready) writes max_total; write it
// only while the block is idle. cfg_ready is always high.
// One word is processed at a time. After acceptance the block reads the
// counts, steps once per entry of the equal-count search (up to 255),
// then reads the characters and swaps them when characters trade places;
// a rescale first adds a pass over the count memory. An index of 0 or
// above 256 goes straight to the result. The next word is taken the cycle
// after a result is registered.
// After reset the count and character memories are initialised by a
// pass during which in_stall stays high.
// A stalled result holds in the output register; the next word may be
// taken and worked on meanwhile, its result waiting until the register
// frees.
module adaptive_freq_model_update
  import afmu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SYM_W-1:0]   in_symbol_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SYM_W-1:0]   out_new_index,
  output logic [CHAR_W-1:0]  out_char_at_index,
  output logic [TOTAL_W-1:0] out_total_count,
  output logic               out_rescaled,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TOTAL_W-1:0] cfg_max_total
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  afmu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  afmu_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_symbol_index   (in_symbol_index),
    .cfg_valid         (cfg_valid),
    .cfg_max_total     (cfg_max_total),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_new_index     (out_new_index),
    .out_char_at_index (out_char_at_index),
    .out_total_count   (out_total_count),
    .out_rescaled      (out_rescaled)
  );

endmodule
